// ----- rtl/cca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg
// Types and fixed constants shared by the calendar clock advance block.
// ----------------------------------------------------------------------------
package cca_pkg;

    // field widths
    localparam int MINUTE_W = 6;
    localparam int HOUR_W   = 8;
    localparam int DAY_W    = 8;
    localparam int LMONTH_W = 4;
    localparam int MONTH_W  = 8;
    localparam int YEAR_W   = 16;
    localparam int DELTA_W  = 8;
    localparam int SPM_W    = 16;
    localparam int ACC_W    = 24;
    localparam int TOTAL_W  = 40;
    localparam int FRAC_W   = 17;
    // minutes into the day, hour * minutes per hour + minute, worst case 255 * 63 + 63
    localparam int N_W      = 14;

    // reset and limit values
    localparam logic [YEAR_W-1:0]  START_YEAR = 16'd2022;
    localparam logic [HOUR_W-1:0]  HOUR_UNSET = 8'd255;
    localparam logic [ACC_W-1:0]   ACC_MAX    = 24'hFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [FRAC_W-1:0]  ONE_Q16    = 17'h1_0000;
    localparam logic [SPM_W-1:0]   SPM_RESET  = 16'd1;

    // month indexes with special handling
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 8'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 8'd11;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    // accepted input item
    typedef struct packed {
        opcode_t               opcode;
        logic [DELTA_W-1:0]    delta_seconds;
        logic [MINUTE_W-1:0]   load_minute;
        logic [HOUR_W-1:0]     load_hour;
        logic [DAY_W-1:0]      load_day;
        logic [LMONTH_W-1:0]   load_month;
        logic [YEAR_W-1:0]     load_year;
    } in_item_t;

    // item after the calendar update, before time of day is worked out
    typedef struct packed {
        logic [MINUTE_W-1:0]   minute;
        logic [HOUR_W-1:0]     hour;
        logic [DAY_W-1:0]      day;
        logic [MONTH_W-1:0]    month;
        logic [YEAR_W-1:0]     year;
        logic [TOTAL_W-1:0]    total_seconds;
        logic                  minute_advanced;
        logic                  recompute;
        logic [N_W-1:0]        day_minutes;
    } cal_item_t;

    // finished result item
    typedef struct packed {
        logic [MINUTE_W-1:0]   minute;
        logic [HOUR_W-1:0]     hour;
        logic [DAY_W-1:0]      day;
        logic [MONTH_W-1:0]    month;
        logic [YEAR_W-1:0]     year;
        logic [FRAC_W-1:0]     time_of_day;
        logic [TOTAL_W-1:0]    total_seconds;
        logic                  minute_advanced;
    } res_item_t;

endpackage

// ----- rtl/calendar_clock_advance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_advance
// Calendar clock: tick items accumulate seconds and advance one minute at a
// time through hour, day, month and year; load items set the time.
//
//   channel  | ports                          | direction
//   ---------+--------------------------------+----------
//   input    | s_valid s_ready s_*            | in
//   result   | m_valid m_ready m_*            | out
//   config   | cfg_wr_en cfg_wr_data          | in
//
// One item per cycle while results are taken; each item passes the input
// register, calendar update, reciprocal multiply and correction into the
// result register, in that order.
// The calendar state updates in the second stage, so each item sees all
// earlier ones. A stalled result holds only the stages behind it that are
// full; empty stages keep taking items. Sync reset sets calendar and valids.
// ----------------------------------------------------------------------------
module calendar_clock_advance import cca_pkg::*; #(
    parameter int MINUTES_PER_HOUR  = 60,
    parameter int HOURS_PER_DAY     = 24,
    parameter int LONG_MONTH_DAYS   = 31,
    parameter int MEDIUM_MONTH_DAYS = 30,
    parameter int SHORT_MONTH_DAYS  = 28
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [SPM_W-1:0]    cfg_wr_data,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [DELTA_W-1:0]  s_delta_seconds,
    input  logic [MINUTE_W-1:0] s_load_minute,
    input  logic [HOUR_W-1:0]   s_load_hour,
    input  logic [DAY_W-1:0]    s_load_day,
    input  logic [LMONTH_W-1:0] s_load_month,
    input  logic [YEAR_W-1:0]   s_load_year,
    // result items
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MINUTE_W-1:0] m_minute,
    output logic [HOUR_W-1:0]   m_hour,
    output logic [DAY_W-1:0]    m_day,
    output logic [MONTH_W-1:0]  m_month,
    output logic [YEAR_W-1:0]   m_year,
    output logic [FRAC_W-1:0]   m_time_of_day,
    output logic [TOTAL_W-1:0]  m_total_seconds,
    output logic                m_minute_advanced
);

    logic [SPM_W-1:0] spm_reg;
    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             cal_ready;
    logic             cal_valid;
    cal_item_t        cal_item;
    logic             frac_ready;
    res_item_t        res_item;

    // seconds per minute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spm_reg <= SPM_RESET;
        end else if (cfg_wr_en) begin
            spm_reg <= cfg_wr_data;
        end
    end

    // input register
    assign s_ready = !in_valid_reg || cal_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.opcode        <= opcode_t'(s_opcode);
            in_item_reg.delta_seconds <= s_delta_seconds;
            in_item_reg.load_minute   <= s_load_minute;
            in_item_reg.load_hour     <= s_load_hour;
            in_item_reg.load_day      <= s_load_day;
            in_item_reg.load_month    <= s_load_month;
            in_item_reg.load_year     <= s_load_year;
        end
    end

    // calendar update
    cca_calendar #(
        .MINUTES_PER_HOUR  (MINUTES_PER_HOUR),
        .HOURS_PER_DAY     (HOURS_PER_DAY),
        .LONG_MONTH_DAYS   (LONG_MONTH_DAYS),
        .MEDIUM_MONTH_DAYS (MEDIUM_MONTH_DAYS),
        .SHORT_MONTH_DAYS  (SHORT_MONTH_DAYS)
    ) u_calendar (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .seconds_per_minute (spm_reg),
        .in_valid           (in_valid_reg),
        .in_ready           (cal_ready),
        .in_item            (in_item_reg),
        .out_valid          (cal_valid),
        .out_ready          (frac_ready),
        .out_item           (cal_item)
    );

    // time of day and result register
    cca_day_frac #(
        .MINUTES_PER_HOUR (MINUTES_PER_HOUR),
        .HOURS_PER_DAY    (HOURS_PER_DAY)
    ) u_day_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cal_valid),
        .in_ready  (frac_ready),
        .in_item   (cal_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (res_item)
    );

    assign m_minute          = res_item.minute;
    assign m_hour            = res_item.hour;
    assign m_day             = res_item.day;
    assign m_month           = res_item.month;
    assign m_year            = res_item.year;
    assign m_time_of_day     = res_item.time_of_day;
    assign m_total_seconds   = res_item.total_seconds;
    assign m_minute_advanced = res_item.minute_advanced;

endmodule

// ----- rtl/cca_calendar.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_calendar
// Calendar state and its one-item update: seconds accumulation, hour
// normalisation, minute/hour/day/month/year carry, saturating total.
// ----------------------------------------------------------------------------
module cca_calendar import cca_pkg::*; #(
    parameter int MINUTES_PER_HOUR  = 60,
    parameter int HOURS_PER_DAY     = 24,
    parameter int LONG_MONTH_DAYS   = 31,
    parameter int MEDIUM_MONTH_DAYS = 30,
    parameter int SHORT_MONTH_DAYS  = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [SPM_W-1:0] seconds_per_minute,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output cal_item_t        out_item
);

    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [ACC_W-1:0]    accum_reg, accum_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic                out_valid_reg;
    cal_item_t           out_item_reg;

    logic                take;
    logic [ACC_W:0]      acc_sum;
    logic [ACC_W-1:0]    acc_sat;
    logic [HOUR_W-1:0]   hour_norm;
    logic [MINUTE_W:0]   mn_inc;
    logic [HOUR_W:0]     hr_inc;
    logic [DAY_W-1:0]    day_inc;
    logic [DAY_W-1:0]    day_limit;
    logic                month_known;
    logic [TOTAL_W:0]    total_sum;
    logic                advanced;
    logic                recompute;
    logic [N_W-1:0]      day_minutes;

    // stage handshake
    assign take     = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // month length for the current month
    always_comb begin
        day_limit   = 8'(LONG_MONTH_DAYS);
        month_known = 1'b1;
        case (month_reg) inside
            8'd0, 8'd2, 8'd4, 8'd6, 8'd7, 8'd9, MONTH_DEC: begin
                day_limit = 8'(LONG_MONTH_DAYS);
            end
            8'd3, 8'd5, 8'd8, 8'd10: begin
                day_limit = 8'(MEDIUM_MONTH_DAYS);
            end
            MONTH_FEB: begin
                day_limit = (year_reg[1:0] == 2'b00) ? 8'(SHORT_MONTH_DAYS + 1)
                                                     : 8'(SHORT_MONTH_DAYS);
            end
            default: begin
                month_known = 1'b0;
            end
        endcase
    end

    // next calendar state for the item at the input
    always_comb begin
        minute_next = minute_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        accum_next  = accum_reg;
        total_next  = total_reg;
        advanced    = 1'b0;
        recompute   = 1'b0;

        acc_sum   = {1'b0, accum_reg} + (ACC_W+1)'(in_item.delta_seconds);
        acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(acc_sat);

        if (hour_reg == HOUR_UNSET) begin
            hour_norm = 8'(HOURS_PER_DAY - 1);
        end else if (hour_reg >= 8'(HOURS_PER_DAY)) begin
            hour_norm = '0;
        end else begin
            hour_norm = hour_reg;
        end

        mn_inc  = {1'b0, minute_reg} + 7'd1;
        hr_inc  = {1'b0, hour_norm} + 9'd1;
        day_inc = day_reg + 8'd1;

        if (in_item.opcode == OP_LOAD) begin
            minute_next = in_item.load_minute;
            hour_next   = in_item.load_hour;
            day_next    = in_item.load_day;
            month_next  = MONTH_W'(in_item.load_month);
            year_next   = in_item.load_year;
            accum_next  = '0;
            recompute   = 1'b1;
        end else begin
            hour_next  = hour_norm;
            accum_next = acc_sat;
            if (acc_sat >= ACC_W'(seconds_per_minute)) begin
                advanced   = 1'b1;
                recompute  = 1'b1;
                accum_next = '0;
                total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                // minute carry chain
                if (mn_inc >= 7'(MINUTES_PER_HOUR)) begin
                    minute_next = '0;
                    if (hr_inc >= 9'(HOURS_PER_DAY)) begin
                        hour_next = '0;
                        day_next  = day_inc;
                        if (month_known && (day_inc >= day_limit)) begin
                            day_next = '0;
                            if (month_reg >= MONTH_DEC) begin
                                month_next = '0;
                                year_next  = year_reg + 16'd1;
                            end else begin
                                month_next = month_reg + 8'd1;
                            end
                        end
                    end else begin
                        hour_next = hr_inc[HOUR_W-1:0];
                    end
                end else begin
                    minute_next = mn_inc[MINUTE_W-1:0];
                end
            end
        end

        day_minutes = N_W'(hour_next) * N_W'(MINUTES_PER_HOUR) + N_W'(minute_next);
    end

    // calendar state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minute_reg <= '0;
            hour_reg   <= '0;
            day_reg    <= '0;
            month_reg  <= '0;
            year_reg   <= START_YEAR;
            accum_reg  <= '0;
            total_reg  <= '0;
        end else if (take) begin
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            accum_reg  <= accum_next;
            total_reg  <= total_next;
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (take) begin
            out_item_reg.minute          <= minute_next;
            out_item_reg.hour            <= hour_next;
            out_item_reg.day             <= day_next;
            out_item_reg.month           <= month_next;
            out_item_reg.year            <= year_next;
            out_item_reg.total_seconds   <= total_next;
            out_item_reg.minute_advanced <= advanced;
            out_item_reg.recompute       <= recompute;
            out_item_reg.day_minutes     <= day_minutes;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef ASSERT_OFF
    // a load always leaves the accumulator empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (in_item.opcode == OP_LOAD)) |=> (accum_reg == '0))
        else $error("accumulator not cleared by load");

    // an advance leaves minute and hour inside their ranges
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.minute_advanced) |->
        ((out_item_reg.minute < MINUTE_W'(MINUTES_PER_HOUR)) &&
         (out_item_reg.hour < HOUR_W'(HOURS_PER_DAY)) && out_item_reg.recompute))
        else $error("advance left time out of range");

    // the total never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (total_reg >= $past(total_reg)))
        else $error("total seconds decreased");
`endif

endmodule

// ----- rtl/cca_day_frac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_day_frac
// Time of day as UQ1.16: rounded division of minutes into the day by the
// minutes per day, by reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module cca_day_frac import cca_pkg::*; #(
    parameter int MINUTES_PER_HOUR = 60,
    parameter int HOURS_PER_DAY    = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cal_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output res_item_t out_item
);

    localparam int unsigned DEN      = MINUTES_PER_HOUR * HOURS_PER_DAY;
    localparam int unsigned HALF_DEN = DEN / 2;
    localparam int          SHIFT    = N_W + 16;
    localparam int          NUM_W    = N_W + 16;
    localparam int          RECIP_W  = SHIFT - 1;
    localparam int          PROD_W   = NUM_W + RECIP_W;
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / DEN;

    // multiply stage
    logic              c_valid_reg;
    cal_item_t         c_item_reg;
    logic [NUM_W-1:0]  c_num_reg;
    logic [PROD_W-1:0] c_prod_reg;
    logic              c_sat_reg;

    // result stage and held fraction
    logic              out_valid_reg;
    res_item_t         out_item_reg;
    logic [FRAC_W-1:0] frac_hold_reg;

    logic              c_take;
    logic              c_ready;
    logic              d_take;
    logic [NUM_W-1:0]  num_c;
    logic [PROD_W-1:0] prod_c;
    logic [15:0]       q_est;
    logic [NUM_W-1:0]  rem;
    logic [15:0]       q_fix;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W-1:0] frac_sel;

    // stage handshakes
    assign c_ready  = !out_valid_reg || out_ready;
    assign d_take   = c_valid_reg && c_ready;
    assign in_ready = !c_valid_reg || c_ready;
    assign c_take   = in_valid && in_ready;

    // numerator with half the divisor added for rounding, times the reciprocal
    assign num_c  = {in_item.day_minutes, 16'h0000} + NUM_W'(HALF_DEN);
    assign prod_c = PROD_W'(num_c) * PROD_W'(RECIP_W'(RECIP));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (in_ready) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_take) begin
            c_item_reg <= in_item;
            c_num_reg  <= num_c;
            c_prod_reg <= prod_c;
            c_sat_reg  <= (in_item.day_minutes >= N_W'(DEN));
        end
    end

    // quotient estimate is low by at most one; fix it from the remainder
    always_comb begin
        q_est    = c_prod_reg[SHIFT +: 16];
        rem      = c_num_reg - NUM_W'(q_est) * NUM_W'(DEN);
        q_fix    = q_est + 16'(rem >= NUM_W'(DEN));
        frac     = c_sat_reg ? ONE_Q16 : {1'b0, q_fix};
        frac_sel = c_item_reg.recompute ? frac : frac_hold_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            frac_hold_reg <= '0;
        end else begin
            if (c_ready) begin
                out_valid_reg <= c_valid_reg;
            end
            if (d_take && c_item_reg.recompute) begin
                frac_hold_reg <= frac;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_take) begin
            out_item_reg.minute          <= c_item_reg.minute;
            out_item_reg.hour            <= c_item_reg.hour;
            out_item_reg.day             <= c_item_reg.day;
            out_item_reg.month           <= c_item_reg.month;
            out_item_reg.year            <= c_item_reg.year;
            out_item_reg.time_of_day     <= frac_sel;
            out_item_reg.total_seconds   <= c_item_reg.total_seconds;
            out_item_reg.minute_advanced <= c_item_reg.minute_advanced;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef ASSERT_OFF
    // time of day never passes one whole day
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_item_reg.time_of_day <= ONE_Q16))
        else $error("time of day above one");

    // below the cap the quotient estimate fits sixteen bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !c_sat_reg) |-> (c_prod_reg[PROD_W-1:SHIFT+16] == '0))
        else $error("quotient estimate overflow");

    // an item that does not recompute shows the held fraction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (d_take && !c_item_reg.recompute) |=>
        (out_item_reg.time_of_day == $past(frac_hold_reg)))
        else $error("held fraction not shown");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for calendar_clock_advance. Directed items cover the
// reset state, month, leap and year carries, and out-of-range load fields.
// Random load-then-tick sequences follow under several minute lengths. Every
// accepted item is run through a local calendar model, and each result item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import cca_pkg::*;

    localparam int MINUTES_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY     = 24;
    localparam int LONG_MONTH_DAYS   = 31;
    localparam int MEDIUM_MONTH_DAYS = 30;
    localparam int SHORT_MONTH_DAYS  = 28;
    localparam int LEAP_PERIOD       = 4;
    localparam int DAY_MINUTES       = MINUTES_PER_HOUR * HOURS_PER_DAY;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX  = '1;
    localparam logic [LMONTH_W-1:0] LMONTH_MAX  = '1;
    localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(MINUTES_PER_HOUR - 1);
    localparam logic [HOUR_W-1:0]   LAST_HOUR   = HOUR_W'(HOURS_PER_DAY - 1);
    localparam int RESULT_LATENCY    = 3;
    localparam int IDLE_LIMIT        = 2000;
    localparam int ITEM_W            = $bits(in_item_t);

    typedef enum logic [MONTH_W-1:0] {
        JAN, FEB, MAR, APR, MAY, JUN, JUL, AUG, SEP, OCT, NOV, DEC
    } month_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PERIODIC
    } ready_mode_t;

    // clock, reset and block inputs, all known from time zero
    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic [SPM_W-1:0]    cfg_wr_data     = '0;
    logic                s_valid         = 1'b0;
    logic                s_opcode        = OP_TICK;
    logic [DELTA_W-1:0]  s_delta_seconds = '0;
    logic [MINUTE_W-1:0] s_load_minute   = '0;
    logic [HOUR_W-1:0]   s_load_hour     = '0;
    logic [DAY_W-1:0]    s_load_day      = '0;
    logic [LMONTH_W-1:0] s_load_month    = '0;
    logic [YEAR_W-1:0]   s_load_year     = '0;
    logic                m_ready         = 1'b0;

    logic                s_ready;
    logic                m_valid;
    logic [MINUTE_W-1:0] m_minute;
    logic [HOUR_W-1:0]   m_hour;
    logic [DAY_W-1:0]    m_day;
    logic [MONTH_W-1:0]  m_month;
    logic [YEAR_W-1:0]   m_year;
    logic [FRAC_W-1:0]   m_time_of_day;
    logic [TOTAL_W-1:0]  m_total_seconds;
    logic                m_minute_advanced;

    // local copy of the calendar state and the minute length
    logic [SPM_W-1:0]    minute_len;
    logic [MINUTE_W-1:0] cal_minute;
    logic [HOUR_W-1:0]   cal_hour;
    logic [DAY_W-1:0]    cal_day;
    logic [MONTH_W-1:0]  cal_month;
    logic [YEAR_W-1:0]   cal_year;
    logic [ACC_W-1:0]    sec_accum;
    logic [TOTAL_W-1:0]  total_secs;
    logic [FRAC_W-1:0]   day_frac;

    res_item_t   expected_times[$];
    res_item_t   result_want;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 16;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int unsigned ready_count = 0;

    calendar_clock_advance #(
        .MINUTES_PER_HOUR  (MINUTES_PER_HOUR),
        .HOURS_PER_DAY     (HOURS_PER_DAY),
        .LONG_MONTH_DAYS   (LONG_MONTH_DAYS),
        .MEDIUM_MONTH_DAYS (MEDIUM_MONTH_DAYS),
        .SHORT_MONTH_DAYS  (SHORT_MONTH_DAYS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_delta_seconds   (s_delta_seconds),
        .s_load_minute     (s_load_minute),
        .s_load_hour       (s_load_hour),
        .s_load_day        (s_load_day),
        .s_load_month      (s_load_month),
        .s_load_year       (s_load_year),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_minute          (m_minute),
        .m_hour            (m_hour),
        .m_day             (m_day),
        .m_month           (m_month),
        .m_year            (m_year),
        .m_time_of_day     (m_time_of_day),
        .m_total_seconds   (m_total_seconds),
        .m_minute_advanced (m_minute_advanced)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // days in a month, 0 for an index that names no month
    function automatic int month_days(logic [MONTH_W-1:0] mon, logic [YEAR_W-1:0] yr);
        case (mon)
            JAN, MAR, MAY, JUL, AUG, OCT, DEC: return LONG_MONTH_DAYS;
            APR, JUN, SEP, NOV: return MEDIUM_MONTH_DAYS;
            FEB: return (yr % LEAP_PERIOD == 0) ? SHORT_MONTH_DAYS + 1 : SHORT_MONTH_DAYS;
            default: return 0;
        endcase
    endfunction

    // fraction of the day in UQ1.16, nearest with ties up, capped at one
    function automatic logic [FRAC_W-1:0] fraction_q16(logic [HOUR_W-1:0] hr,
                                                       logic [MINUTE_W-1:0] mn);
        longint unsigned n;
        longint unsigned q;
        n = hr;
        n = n * MINUTES_PER_HOUR + mn;
        q = (n * ONE_Q16 + DAY_MINUTES / 2) / DAY_MINUTES;
        return (q > ONE_Q16) ? ONE_Q16 : q[FRAC_W-1:0];
    endfunction

    // apply one item to the local calendar and give the result it should produce
    task automatic calendar_step(input in_item_t it, output res_item_t r);
        int unsigned     acc;
        int              mn;
        int              hr;
        int              len;
        longint unsigned tot;
        logic            advanced;
        advanced = 1'b0;
        if (it.opcode == OP_TICK) begin
            acc = sec_accum + it.delta_seconds;
            sec_accum = (acc > ACC_MAX) ? ACC_MAX : acc[ACC_W-1:0];
            // hour normalisation comes before the advance test
            if (cal_hour == HOUR_UNSET) begin
                cal_hour = LAST_HOUR;
            end else if (cal_hour >= HOURS_PER_DAY) begin
                cal_hour = '0;
            end
            if (sec_accum >= minute_len) begin
                mn = cal_minute + 1;
                if (mn >= MINUTES_PER_HOUR) begin
                    hr = cal_hour + 1;
                    if (hr >= HOURS_PER_DAY) begin
                        // day carry, month and year only for a real month
                        len = month_days(cal_month, cal_year);
                        cal_day = cal_day + 1'b1;
                        if (len != 0 && cal_day >= len) begin
                            cal_day = '0;
                            if (cal_month == MONTH_DEC) begin
                                cal_month = JAN;
                                cal_year  = cal_year + 1'b1;
                            end else begin
                                cal_month = cal_month + 1'b1;
                            end
                        end
                        hr = 0;
                    end
                    cal_hour = hr[HOUR_W-1:0];
                    mn = 0;
                end
                cal_minute = mn[MINUTE_W-1:0];
                tot = total_secs + sec_accum;
                total_secs = (tot > TOTAL_MAX) ? TOTAL_MAX : tot[TOTAL_W-1:0];
                sec_accum = '0;
                day_frac = fraction_q16(cal_hour, cal_minute);
                advanced = 1'b1;
            end
        end else begin
            cal_minute = it.load_minute;
            cal_hour   = it.load_hour;
            cal_day    = it.load_day;
            cal_month  = MONTH_W'(it.load_month);
            cal_year   = it.load_year;
            sec_accum  = '0;
            day_frac   = fraction_q16(cal_hour, cal_minute);
        end
        r.minute          = cal_minute;
        r.hour            = cal_hour;
        r.day             = cal_day;
        r.month           = cal_month;
        r.year            = cal_year;
        r.time_of_day     = day_frac;
        r.total_seconds   = total_secs;
        r.minute_advanced = advanced;
    endtask

    // offer one item, predict its result once accepted, then maybe pause
    task automatic send_item(input in_item_t it);
        res_item_t predicted;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_opcode        <= it.opcode;
        s_delta_seconds <= it.delta_seconds;
        s_load_minute   <= it.load_minute;
        s_load_hour     <= it.load_hour;
        s_load_day      <= it.load_day;
        s_load_month    <= it.load_month;
        s_load_year     <= it.load_year;
        do @(posedge aclk); while (!s_ready);
        calendar_step(it, predicted);
        expected_times.push_back(predicted);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    // tick item, the unused load fields carry random bits
    task automatic send_tick(input logic [DELTA_W-1:0] delta);
        in_item_t it;
        it = ITEM_W'({$urandom, $urandom});
        it.opcode        = OP_TICK;
        it.delta_seconds = delta;
        send_item(it);
    endtask

    // load item, the unused delta carries random bits
    task automatic send_load(input logic [MINUTE_W-1:0] mn, input logic [HOUR_W-1:0] hr,
                             input logic [DAY_W-1:0] dy, input logic [LMONTH_W-1:0] mon,
                             input logic [YEAR_W-1:0] yr);
        in_item_t it;
        it = ITEM_W'({$urandom, $urandom});
        it.opcode      = OP_LOAD;
        it.load_minute = mn;
        it.load_hour   = hr;
        it.load_day    = dy;
        it.load_month  = mon;
        it.load_year   = yr;
        send_item(it);
    endtask

    // stop offering items and wait for every result to come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_times.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY) @(negedge aclk);
    endtask

    // minute length, written only once the block is idle
    task automatic set_minute_length(input logic [SPM_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        minute_len = value;
    endtask

    task automatic apply_reset();
        minute_len = SPM_RESET;
        cal_minute = '0;
        cal_hour   = '0;
        cal_day    = '0;
        cal_month  = JAN;
        cal_year   = START_YEAR;
        sec_accum  = '0;
        total_secs = '0;
        day_frac   = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // load near a day boundary and tick across it, with some noise between
    task automatic run_calendar_sequences(input int n_items);
        int                  sent;
        int                  ticks;
        int                  pick;
        int                  len;
        logic [YEAR_W-1:0]   yr;
        logic [LMONTH_W-1:0] mon;
        logic [HOUR_W-1:0]   hr;
        logic [DAY_W-1:0]    dy;
        logic [MINUTE_W-1:0] mn;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                yr  = YEAR_W'($urandom);
                mon = LMONTH_W'($urandom_range(0, 11));
                if ($urandom_range(0, 3) == 0) yr[1:0] = 2'b00;
                if ($urandom_range(0, 15) == 0) begin
                    yr  = '1;
                    mon = LMONTH_W'(DEC);
                end
                len = month_days(MONTH_W'(mon), yr);
                dy  = DAY_W'(len - int'($urandom_range(1, 3)));
                hr  = ($urandom_range(0, 15) == 0) ? HOUR_UNSET :
                      HOUR_W'($urandom_range(HOURS_PER_DAY - 2, HOURS_PER_DAY - 1));
                mn  = ($urandom_range(0, 7) == 0) ?
                      MINUTE_W'($urandom_range(MINUTES_PER_HOUR, MINUTE_MAX)) :
                      MINUTE_W'($urandom_range(MINUTES_PER_HOUR - 10, MINUTES_PER_HOUR - 1));
                send_load(mn, hr, dy, mon, yr);
                ticks = $urandom_range(1, 16);
                repeat (ticks) send_tick(DELTA_W'($urandom_range(0, 255)));
                sent += ticks + 1;
            end else if (pick < 9) begin
                // any load the field widths allow
                send_load(MINUTE_W'($urandom), HOUR_W'($urandom), DAY_W'($urandom),
                          LMONTH_W'($urandom), YEAR_W'($urandom));
                sent++;
            end else begin
                ticks = $urandom_range(1, 8);
                repeat (ticks) send_tick(DELTA_W'($urandom));
                sent += ticks;
            end
        end
    endtask

    // state straight after reset, then a first advance
    task automatic test_reset_state();
        send_tick(8'd0);
        send_tick(8'd255);
    endtask

    // month, leap and year carries from the last minute of a day
    task automatic test_calendar_carries();
        send_load(LAST_MINUTE, LAST_HOUR, 8'd30, LMONTH_W'(DEC), 16'hFFFF);
        send_tick(8'd1);
        send_load(LAST_MINUTE, LAST_HOUR, 8'd28, LMONTH_W'(FEB), 16'd2024);
        send_tick(8'd1);
        send_load(LAST_MINUTE, LAST_HOUR, 8'd27, LMONTH_W'(FEB), 16'd2023);
        send_tick(8'd1);
        send_load(LAST_MINUTE, LAST_HOUR, 8'd27, LMONTH_W'(FEB), 16'd2024);
        send_tick(8'd1);
        send_load(LAST_MINUTE, LAST_HOUR, 8'd29, LMONTH_W'(APR), 16'd2022);
        send_tick(8'd1);
    endtask

    // unset hour, oversized hour and minute, day and month past their range
    task automatic test_out_of_range_fields();
        send_load(MINUTE_MAX, HOUR_UNSET, 8'd255, LMONTH_MAX, 16'd0);
        send_tick(8'd0);
        send_tick(8'd1);
        send_load(6'd17, HOUR_W'(HOURS_PER_DAY), 8'd3, 4'd5, 16'd1999);
        send_tick(8'd1);
        send_load(MINUTE_W'(MINUTES_PER_HOUR), 8'd5, 8'd0, LMONTH_W'(JAN), START_YEAR);
        send_tick(8'd2);
    endtask

    // a zero minute length advances on every tick, even with no seconds
    task automatic test_zero_minute_length();
        set_minute_length(16'd0);
        send_tick(8'd0);
        send_tick(8'd0);
    endtask

    task automatic test_random_calendar();
        set_minute_length(16'd1);
        run_calendar_sequences(500);
        set_minute_length(SPM_W'($urandom_range(2, 20)));
        run_calendar_sequences(300);
    endtask

    // longest minute, mostly full ticks so that it is reached
    task automatic test_long_minute();
        set_minute_length(16'hFFFF);
        repeat (360) begin
            if ($urandom_range(0, 3) != 0) send_tick(8'd255);
            else send_tick(DELTA_W'($urandom));
        end
    endtask

    task automatic test_random_minute_length();
        repeat (3) begin
            set_minute_length(SPM_W'($urandom_range(1, 600)));
            run_calendar_sequences(110);
        end
    endtask

    // result receiver, stall pattern changes whenever its countdown runs out
    always @(negedge aclk) begin
        if (ready_count == 0) begin
            ready_mode  <= ready_mode_t'($urandom_range(0, 3));
            ready_count <= $urandom_range(32, 256);
        end else begin
            ready_count <= ready_count - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_SELDOM: m_ready <= ($urandom_range(0, 3) == 0);
            default:    m_ready <= (ready_count[2:0] < 3'd5);
        endcase
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each result item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_times.size() == 0) begin
                $error("result item with no prediction waiting");
                mismatches++;
            end else begin
                result_want = expected_times.pop_front();
                check_field("minute", result_want.minute, m_minute);
                check_field("hour", result_want.hour, m_hour);
                check_field("day", result_want.day, m_day);
                check_field("month", result_want.month, m_month);
                check_field("year", result_want.year, m_year);
                check_field("time_of_day", result_want.time_of_day, m_time_of_day);
                check_field("total_seconds", result_want.total_seconds, m_total_seconds);
                check_field("minute_advanced", result_want.minute_advanced,
                            m_minute_advanced);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no item accepted for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        apply_reset();
        test_reset_state();
        test_calendar_carries();
        test_out_of_range_fields();
        test_zero_minute_length();
        test_random_calendar();
        test_long_minute();
        test_random_minute_length();
        drain_results();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
